FILE: sv/qse_pkg.sv
// Package for the quadrature speed estimator: operation codes, register map,
// reset values and fixed-point constants. No dependencies.
package qse_pkg;

    // Default number of periods averaged for the speed estimate
    localparam int unsigned PERIOD_TAPS_DEF = 8;

    // Configuration port geometry
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    // Register widths and reset values
    localparam int unsigned DPC_W     = 32;
    localparam int unsigned TIMEOUT_W = 24;
    localparam logic [DPC_W-1:0]     DPC_RESET     = 32'd65536;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd100000;
    localparam logic                 INVERT_RESET  = 1'b0;

    // Microseconds per second, used to scale counts per microsecond
    localparam int unsigned US_PER_SEC_W = 20;
    localparam logic [US_PER_SEC_W-1:0] US_PER_SEC = 20'd1000000;

    // Largest magnitude of a signed Q48.16 speed
    localparam logic [63:0] SPEED_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    // Operation codes carried by each input item
    typedef enum logic [1:0] {
        OP_EDGE   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Register indexes (word address = byte address / 4)
    typedef enum logic [1:0] {
        REG_DPC     = 2'd0,
        REG_TIMEOUT = 2'd1,
        REG_INVERT  = 2'd2,
        REG_SPARE   = 2'd3
    } reg_idx_t;

    // Motion direction reported with a sample
    typedef enum logic [1:0] {
        MOTION_STOP    = 2'd0,
        MOTION_FORWARD = 2'd1,
        MOTION_REVERSE = 2'd2,
        MOTION_SPARE   = 2'd3
    } motion_t;

endpackage

FILE: sv/qse_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read. No dependencies.
module qse_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/quadrature_speed_estimator_unit.sv
// Quadrature speed estimator top level: edge counting, period ring in RAM,
// serial divider for speed. Depends on qse_pkg and qse_ram.
//
// Usage:
//  - Input channel (s_*): one transfer per item. s_operation selects an edge
//    event, a sample, a clear, or no-op. One item is worked on at a time;
//    s_ready is high only while the block is idle.
//  - Result channel (m_*): exactly one transfer per input item, held in an
//    output register; the block returns to idle and takes the next item while
//    a result still waits for m_ready.
//  - Path from input transfer to m_valid: an edge event has a ring RAM read
//    and a read-modify-write (ST_EDGE); clear or no-op goes to ST_FIN; a
//    sample that is stopped or has an empty ring passes ST_SAMPLE; a sample
//    that divides has two multiplies (ST_SAMPLE, ST_MUL), 64 steps of the
//    one-bit-per-cycle restoring divider (ST_DIV) and saturation (ST_SAT).
//  - If m_ready stays low, a finished item waits in the last stage until the
//    output register frees; no input is taken meanwhile.
//  - Reset (aresetn low, synchronous) zeroes count, times, ring valid bits and
//    registers to their defaults; ring entries read as zero until written.
//  - APB port: distance_per_count at 0x0, stop_timeout at 0x4,
//    invert_direction at 0x8; write only while idle.
module quadrature_speed_estimator_unit #(
    parameter int unsigned PERIOD_TAPS = qse_pkg::PERIOD_TAPS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [qse_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [qse_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [qse_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    // input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_operation,
    input  logic [31:0]                     s_now_us,
    input  logic                            s_level_a,
    input  logic                            s_level_b,
    input  logic                            s_edge_mode,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [31:0]              m_position_count,
    output logic signed [63:0]              m_travelled,
    output logic signed [63:0]              m_velocity,
    output logic [1:0]                      m_motion_sense,
    output logic                            m_halted
);

    localparam int unsigned SlotW   = $clog2(PERIOD_TAPS);
    localparam int unsigned TapW    = $clog2(PERIOD_TAPS + 1);
    localparam int unsigned TotalW  = 32 + SlotW;
    localparam int unsigned Prod1W  = qse_pkg::DPC_W + TapW;
    localparam int unsigned Prod2W  = Prod1W + qse_pkg::US_PER_SEC_W;
    localparam int unsigned BitW    = 6;
    localparam logic [SlotW-1:0] LastSlot = SlotW'(PERIOD_TAPS - 1);
    localparam logic [TapW-1:0]  Taps     = TapW'(PERIOD_TAPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE,
        ST_SAMPLE,
        ST_MUL,
        ST_DIV,
        ST_SAT,
        ST_FIN
    } state_t;

    // configuration registers
    logic [qse_pkg::DPC_W-1:0]     dpc_reg;
    logic [qse_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic                          invert_reg;

    // control and architectural state
    state_t                state_reg;
    logic [31:0]           count_reg;
    logic [31:0]           last_reg;
    logic [TotalW-1:0]     total_reg;
    logic [SlotW-1:0]      slot_reg;
    logic                  fwd_reg;
    logic [PERIOD_TAPS-1:0] vld_reg;
    logic [BitW-1:0]       bit_reg;
    logic                  m_valid_reg;

    // datapath registers
    logic [31:0]           now_reg;
    logic                  up_reg;
    logic                  smp_reg;
    logic [Prod1W-1:0]     prod1_reg;
    logic [63:0]           num_reg;
    logic [TotalW-1:0]     rem_reg;
    logic [63:0]           mag_reg;
    logic signed [31:0]    pos_reg;
    logic signed [63:0]    trav_reg;
    logic signed [63:0]    vel_reg;
    logic [1:0]            sense_reg;
    logic                  halt_reg;

    // combinational signals
    logic                  s_xfer;
    logic                  cfg_wr;
    qse_pkg::reg_idx_t     cfg_idx;
    qse_pkg::op_t          s_op;
    logic                  dir_up;
    logic [31:0]           ring_rdata;
    logic [31:0]           old_period;
    logic [31:0]           period;
    logic [TotalW-1:0]     total_upd;
    logic [31:0]           elapsed;
    logic                  timed_out;
    logic [Prod2W-1:0]     prod2;
    logic [TotalW:0]       rem_shift;
    logic                  quot_bit;
    logic [TotalW-1:0]     rem_upd;
    logic                  fin_load;
    logic signed [65:0]    trav_full;
    logic [63:0]           vel_mag_neg;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign cfg_idx  = qse_pkg::reg_idx_t'(paddr[3:2]);
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_xfer   = s_valid & s_ready;
    assign s_op     = qse_pkg::op_t'(s_operation);
    assign dir_up   = (s_level_a == (s_level_b ^ ~invert_reg ^ s_edge_mode));
    assign fin_load = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    // register read-back
    always_comb begin
        unique case (cfg_idx)
            qse_pkg::REG_DPC:     prdata = dpc_reg;
            qse_pkg::REG_TIMEOUT: prdata = {8'd0, timeout_reg};
            qse_pkg::REG_INVERT:  prdata = {31'd0, invert_reg};
            default:              prdata = '0;
        endcase
    end

    // period ring storage; read on edge transfer, written back in the next cycle (ST_EDGE)
    qse_ram #(
        .WIDTH(32),
        .DEPTH(PERIOD_TAPS)
    ) u_ring (
        .aclk  (aclk),
        .we    (state_reg == ST_EDGE),
        .waddr (slot_reg),
        .wdata (period),
        .re    (s_xfer && (s_op == qse_pkg::OP_EDGE)),
        .raddr (slot_reg),
        .rdata (ring_rdata)
    );

    // edge event: replace the oldest period and update the running total
    assign old_period = vld_reg[slot_reg] ? ring_rdata : 32'd0;
    assign period     = now_reg - last_reg;
    assign total_upd  = total_reg - TotalW'(old_period) + TotalW'(period);

    // stop detection
    assign elapsed   = now_reg - last_reg;
    assign timed_out = (elapsed >= {8'd0, timeout_reg});

    // numerator scaling, full-width product in Prod2W bits
    assign prod2 = prod1_reg * Prod2W'(qse_pkg::US_PER_SEC);

    // one restoring-division step per cycle
    assign rem_shift = {rem_reg, num_reg[63]};
    assign quot_bit  = (rem_shift >= {1'b0, total_reg});
    assign rem_upd   = quot_bit ? TotalW'(rem_shift - {1'b0, total_reg})
                                : TotalW'(rem_shift);

    // result fields
    assign trav_full   = $signed({count_reg[31], count_reg}) * $signed({1'b0, dpc_reg});
    assign vel_mag_neg = 64'd0 - mag_reg;

    // control, configuration and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            dpc_reg     <= qse_pkg::DPC_RESET;
            timeout_reg <= qse_pkg::TIMEOUT_RESET;
            invert_reg  <= qse_pkg::INVERT_RESET;
            count_reg   <= '0;
            last_reg    <= '0;
            total_reg   <= '0;
            slot_reg    <= '0;
            fwd_reg     <= 1'b0;
            vld_reg     <= '0;
            bit_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_idx)
                    qse_pkg::REG_DPC:     dpc_reg     <= pwdata;
                    qse_pkg::REG_TIMEOUT: timeout_reg <= pwdata[qse_pkg::TIMEOUT_W-1:0];
                    qse_pkg::REG_INVERT:  invert_reg  <= pwdata[0];
                    default:              ;
                endcase
            end

            if (fin_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_xfer) begin
                        unique case (s_op)
                            qse_pkg::OP_EDGE:   state_reg <= ST_EDGE;
                            qse_pkg::OP_SAMPLE: state_reg <= ST_SAMPLE;
                            qse_pkg::OP_CLEAR: begin
                                count_reg <= '0;
                                total_reg <= '0;
                                vld_reg   <= '0;
                                state_reg <= ST_FIN;
                            end
                            qse_pkg::OP_NONE:   state_reg <= ST_FIN;
                        endcase
                    end
                end
                ST_EDGE: begin
                    total_reg         <= total_upd;
                    vld_reg[slot_reg] <= 1'b1;
                    slot_reg          <= (slot_reg == LastSlot) ? '0 : slot_reg + 1'b1;
                    last_reg          <= now_reg;
                    count_reg         <= up_reg ? count_reg + 32'd1 : count_reg - 32'd1;
                    fwd_reg           <= up_reg;
                    state_reg         <= ST_FIN;
                end
                ST_SAMPLE: begin
                    if (timed_out) begin
                        last_reg  <= now_reg - {8'd0, timeout_reg};
                        state_reg <= ST_FIN;
                    end else if (total_reg == '0) begin
                        state_reg <= ST_FIN;
                    end else begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    bit_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    bit_reg <= bit_reg + 1'b1;
                    if (bit_reg == '1) begin
                        state_reg <= ST_SAT;
                    end
                end
                ST_SAT: begin
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (fin_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath: item capture, multiplier, divider and output register
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            now_reg <= s_now_us;
            up_reg  <= dir_up;
            smp_reg <= (s_op == qse_pkg::OP_SAMPLE);
            mag_reg <= '0;
        end

        if (state_reg == ST_SAMPLE) begin
            prod1_reg <= dpc_reg * Taps;
            if (!timed_out && total_reg == '0) begin
                mag_reg <= qse_pkg::SPEED_MAX;
            end
        end

        if (state_reg == ST_MUL) begin
            num_reg <= 64'(prod2);
            rem_reg <= '0;
        end

        if (state_reg == ST_DIV) begin
            num_reg <= {num_reg[62:0], quot_bit};
            rem_reg <= rem_upd;
        end

        // quotient at or above 2^63 saturates
        if (state_reg == ST_SAT) begin
            mag_reg <= num_reg[63] ? qse_pkg::SPEED_MAX : num_reg;
        end

        if (fin_load) begin
            pos_reg  <= $signed(count_reg);
            trav_reg <= trav_full[63:0];
            if (!smp_reg) begin
                vel_reg   <= '0;
                sense_reg <= qse_pkg::MOTION_STOP;
                halt_reg  <= 1'b0;
            end else if (mag_reg == '0) begin
                vel_reg   <= '0;
                sense_reg <= qse_pkg::MOTION_STOP;
                halt_reg  <= 1'b1;
            end else if (fwd_reg) begin
                vel_reg   <= $signed(mag_reg);
                sense_reg <= qse_pkg::MOTION_FORWARD;
                halt_reg  <= 1'b0;
            end else begin
                vel_reg   <= $signed(vel_mag_neg);
                sense_reg <= qse_pkg::MOTION_REVERSE;
                halt_reg  <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_position_count = pos_reg;
    assign m_travelled      = trav_reg;
    assign m_velocity       = vel_reg;
    assign m_motion_sense   = sense_reg;
    assign m_halted         = halt_reg;

    // an empty ring always has a zero running total
    a_total_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg == '0) |-> (total_reg == '0))
        else $error("period total nonzero with empty ring");

    // the divider only runs with a nonzero divisor
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (total_reg != '0))
        else $error("divider started with zero period total");

    // one item at a time: a transfer closes the input until the result is loaded
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> !s_ready)
        else $error("input accepted while an item is in progress");

    // a halted result carries zero speed and no direction
    a_halt_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_halted) |-> (m_velocity == '0 &&
                                   m_motion_sense == qse_pkg::MOTION_STOP))
        else $error("halted result with nonzero speed");

    // the output register is not reloaded while a result waits
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_position_count) &&
                                   $stable(m_velocity)))
        else $error("pending result overwritten");

endmodule
